// ===== hdl/tdl_pkg.sv =====
// Shared types, token codes and character tables of the table-driven lexer.
`default_nettype none

package tdl_pkg;

  // Token kinds.
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_ERR      = 6'd1;
  localparam logic [5:0] K_IDENT    = 6'd2;
  localparam logic [5:0] K_NUM      = 6'd3;
  localparam logic [5:0] K_ASSIGN   = 6'd4;
  localparam logic [5:0] K_EQ       = 6'd5;
  localparam logic [5:0] K_COLON    = 6'd6;
  localparam logic [5:0] K_COLON_EQ = 6'd7;
  localparam logic [5:0] K_NE       = 6'd8;
  localparam logic [5:0] K_LE       = 6'd9;
  localparam logic [5:0] K_GE       = 6'd10;
  localparam logic [5:0] K_PLUS     = 6'd11;
  localparam logic [5:0] K_MINUS    = 6'd12;
  localparam logic [5:0] K_STAR     = 6'd13;
  localparam logic [5:0] K_SLASH    = 6'd14;
  localparam logic [5:0] K_PERCENT  = 6'd15;
  localparam logic [5:0] K_DOT      = 6'd16;
  localparam logic [5:0] K_LPAREN   = 6'd17;
  localparam logic [5:0] K_RPAREN   = 6'd18;
  localparam logic [5:0] K_COMMA    = 6'd19;
  localparam logic [5:0] K_LBRACE   = 6'd20;
  localparam logic [5:0] K_RBRACE   = 6'd21;
  localparam logic [5:0] K_SEMI     = 6'd22;
  localparam logic [5:0] K_LBRACKET = 6'd23;
  localparam logic [5:0] K_RBRACKET = 6'd24;
  localparam logic [5:0] K_KEYWORD0 = 6'd25;

  // Error codes.
  localparam logic [2:0] E_NONE       = 3'd0;
  localparam logic [2:0] E_INVALID    = 3'd1;
  localparam logic [2:0] E_TOO_LONG   = 3'd2;
  localparam logic [2:0] E_UNCLOSED   = 3'd3;
  localparam logic [2:0] E_INCOMPLETE = 3'd4;

  // Scanner states.
  localparam logic [4:0] ST_START = 5'd0;
  localparam logic [4:0] ST_IDENT = 5'd1;
  localparam logic [4:0] ST_NUM   = 5'd2;
  localparam logic [4:0] ST_EQ    = 5'd3;
  localparam logic [4:0] ST_COLON = 5'd4;
  localparam logic [4:0] ST_BANG  = 5'd5;
  localparam logic [4:0] ST_LT    = 5'd6;
  localparam logic [4:0] ST_GT    = 5'd7;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_EQ      = 8'h3d;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_LT      = 8'h3c;
  localparam logic [7:0] CH_GT      = 8'h3e;

  // Keyword table: text packed with the first character in the top byte.
  localparam int NUM_KEYWORDS = 17;
  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'h7374_6172_7400_0000,  // start
    64'h7374_6f70_0000_0000,  // stop
    64'h7265_7065_6174_0000,  // repeat
    64'h756e_7469_6c00_0000,  // until
    64'h7768_6f6c_6500_0000,  // whole
    64'h6c61_6265_6c00_0000,  // label
    64'h7175_6974_0000_0000,  // quit
    64'h6c69_7374_656e_0000,  // listen
    64'h7965_6c6c_0000_0000,  // yell
    64'h6d61_696e_0000_0000,  // main
    64'h706f_7274_616c_0000,  // portal
    64'h6966_0000_0000_0000,  // if
    64'h7468_656e_0000_0000,  // then
    64'h7069_636b_0000_0000,  // pick
    64'h6465_636c_6172_6500,  // declare
    64'h6173_7369_676e_0000,  // assign
    64'h7072_6f63_0000_0000   // proc
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd5, 4'd4, 4'd6, 4'd5, 4'd5, 4'd5, 4'd4, 4'd6, 4'd4,
    4'd4, 4'd6, 4'd2, 4'd4, 4'd4, 4'd7, 4'd6, 4'd4
  };

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // One result item.
  typedef struct packed {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] line;
    logic [63:0] text;
    logic [3:0]  len;
    logic        last;
  } result_t;

  function automatic logic is_space(input logic [7:0] ch);
    return (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0d));
  endfunction

  function automatic logic is_alpha(input logic [7:0] ch);
    return ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a)) ||
           (ch == 8'h5f);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= 8'h30) && (ch <= 8'h39);
  endfunction

  // Identifier or keyword kind for buffered text; all compares in parallel.
  function automatic logic [5:0] kw_kind(input logic [63:0] txt, input logic [3:0] n);
    logic [5:0] kind;
    kind = K_IDENT;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if ((KW_LEN[k] == n) && (KW_TEXT[k] == txt)) begin
        kind = K_KEYWORD0 + 6'(k);
      end
    end
    return kind;
  endfunction

  // Kind of a single-character operator, or end of file code when none.
  function automatic logic [5:0] op_kind(input logic [7:0] ch);
    logic [5:0] kind;
    case (ch)
      8'h2b:   kind = K_PLUS;
      8'h2d:   kind = K_MINUS;
      8'h2a:   kind = K_STAR;
      8'h2f:   kind = K_SLASH;
      8'h25:   kind = K_PERCENT;
      8'h2e:   kind = K_DOT;
      8'h28:   kind = K_LPAREN;
      8'h29:   kind = K_RPAREN;
      8'h2c:   kind = K_COMMA;
      8'h7b:   kind = K_LBRACE;
      8'h7d:   kind = K_RBRACE;
      8'h3b:   kind = K_SEMI;
      8'h5b:   kind = K_LBRACKET;
      8'h5d:   kind = K_RBRACKET;
      default: kind = K_EOF;
    endcase
    return kind;
  endfunction

  function automatic result_t mk_res(input logic [5:0] kind, input logic [2:0] err,
                                     input logic [15:0] line, input logic [63:0] txt,
                                     input logic [3:0] n);
    result_t r;
    r.kind = kind;
    r.err  = err;
    r.line = line;
    r.text = txt;
    r.len  = n;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/table_driven_lexer.sv =====
// Top level of the table-driven lexer: stream ports, scanner core and result queue.
// A result can be taken at the earliest in the cycle after the transfer of the character causing it.
// One character per cycle while the queue has room; the result port moves one result per cycle, so
// a character giving two results is absorbed by the four-entry queue.
// Input is taken while the queue has room for two results.
// Reset (synchronous, rst high): start state, empty text, line 1, no comment, queue empty.
`default_nettype none

module table_driven_lexer #(
  parameter int MAX_TEXT_LEN = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input characters.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_byte
  input  wire logic        s_tlast,   // end_of_input
  // Result tokens.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // [5:0] token_kind, [8:6] error_code,
                                      // [24:9] line_number, [88:25] token_text,
                                      // [92:89] text_length, [95:93] zero
  output logic             m_tlast,   // last_result
  // Start line register.
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import tdl_pkg::*;

  logic       accept;
  result_t    res0;
  result_t    res1;
  logic [1:0] nres;
  result_t    head;
  logic       room2;

  assign accept = s_tvalid && s_tready;

  tdl_core #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .ch        (s_tdata),
    .eoi       (s_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res0      (res0),
    .res1      (res1),
    .nres      (nres)
  );

  tdl_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (accept ? nres : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (m_tready),
    .head      (head),
    .not_empty (m_tvalid),
    .room2     (room2)
  );

  assign s_tready = room2;

  // Pack the queue head onto the output stream.
  assign m_tdata = {3'd0, head.len, head.text, head.line, head.err, head.kind};
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== hdl/tdl_core.sv =====
// Scanner state and the single-pass step that turns one character into results.
`default_nettype none

module tdl_core #(
  parameter int MAX_TEXT_LEN = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      ch,
  input  wire logic            eoi,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata,
  output tdl_pkg::result_t     res0,
  output tdl_pkg::result_t     res1,
  output logic [1:0]           nres
);
  import tdl_pkg::*;

  localparam logic [3:0] MaxLen = 4'(MAX_TEXT_LEN);

  logic [4:0]  scan_state;
  logic [63:0] text_buffer;
  logic [3:0]  text_count;
  logic [15:0] line_counter;
  logic        in_comment;
  logic [15:0] comment_start_line;

  logic [4:0]  st;
  logic [63:0] bf;
  logic [3:0]  ct;
  logic [15:0] ln;
  logic        ic;
  logic [15:0] cs;
  logic        restart;
  logic        do_append;
  logic [5:0]  opk;
  result_t     res [2];

  // One step of the scanner, worked out from the current state and character.
  always_comb begin
    st        = scan_state;
    bf        = text_buffer;
    ct        = text_count;
    ln        = line_counter;
    ic        = in_comment;
    cs        = comment_start_line;
    nres      = 2'd0;
    res[0]    = '0;
    res[1]    = '0;
    restart   = 1'b0;
    do_append = 1'b0;
    opk       = op_kind(ch);

    if (eoi) begin
      // End of input: pending token or open comment, then the eof marker.
      if (ic) begin
        res[nres[0]] = mk_res(K_ERR, E_UNCLOSED, cs, 64'd0, 4'd0);
        nres = nres + 2'd1;
        ic = 1'b0;
      end else begin
        case (st)
          ST_IDENT: begin
            res[nres[0]] = mk_res(kw_kind(bf, ct), E_NONE, ln, bf, ct);
            nres = nres + 2'd1;
          end
          ST_NUM: begin
            res[nres[0]] = mk_res(K_NUM, E_NONE, ln, bf, ct);
            nres = nres + 2'd1;
          end
          ST_EQ: begin
            res[nres[0]] = mk_res(K_ASSIGN, E_NONE, ln, {CH_EQ, 56'd0}, 4'd1);
            nres = nres + 2'd1;
          end
          ST_COLON: begin
            res[nres[0]] = mk_res(K_COLON, E_NONE, ln, {CH_COLON, 56'd0}, 4'd1);
            nres = nres + 2'd1;
          end
          ST_BANG: begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_BANG, 56'd0}, 4'd1);
            nres = nres + 2'd1;
          end
          ST_LT: begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_LT, 56'd0}, 4'd1);
            nres = nres + 2'd1;
          end
          ST_GT: begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_GT, 56'd0}, 4'd1);
            nres = nres + 2'd1;
          end
          default: begin
          end
        endcase
      end
      st = ST_START;
      bf = '0;
      ct = '0;
      res[nres[0]] = mk_res(K_EOF, E_NONE, ln, 64'd0, 4'd0);
      nres = nres + 2'd1;
    end else if (ic) begin
      // Inside a comment only the closing mark and newlines count.
      if (ch == CH_HASH) begin
        ic = 1'b0;
      end else if (ch == CH_NEWLINE) begin
        ln = ln + 16'd1;
      end
    end else begin
      case (st)
        ST_IDENT: begin
          if (is_alpha(ch) || is_digit(ch)) begin
            do_append = 1'b1;
          end else begin
            res[nres[0]] = mk_res(kw_kind(bf, ct), E_NONE, ln, bf, ct);
            nres = nres + 2'd1;
            restart = 1'b1;
          end
        end
        ST_NUM: begin
          if (is_digit(ch)) begin
            do_append = 1'b1;
          end else begin
            res[nres[0]] = mk_res(K_NUM, E_NONE, ln, bf, ct);
            nres = nres + 2'd1;
            restart = 1'b1;
          end
        end
        ST_EQ: begin
          if (ch == CH_EQ) begin
            res[nres[0]] = mk_res(K_EQ, E_NONE, ln, {CH_EQ, CH_EQ, 48'd0}, 4'd2);
          end else begin
            res[nres[0]] = mk_res(K_ASSIGN, E_NONE, ln, {CH_EQ, 56'd0}, 4'd1);
            restart = 1'b1;
          end
          nres = nres + 2'd1;
          st = ST_START;
        end
        ST_COLON: begin
          if (ch == CH_EQ) begin
            res[nres[0]] = mk_res(K_COLON_EQ, E_NONE, ln, {CH_COLON, CH_EQ, 48'd0}, 4'd2);
          end else begin
            res[nres[0]] = mk_res(K_COLON, E_NONE, ln, {CH_COLON, 56'd0}, 4'd1);
            restart = 1'b1;
          end
          nres = nres + 2'd1;
          st = ST_START;
        end
        ST_BANG: begin
          if (ch == CH_EQ) begin
            res[nres[0]] = mk_res(K_NE, E_NONE, ln, {CH_BANG, CH_EQ, 48'd0}, 4'd2);
          end else begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_BANG, 56'd0}, 4'd1);
            restart = 1'b1;
          end
          nres = nres + 2'd1;
          st = ST_START;
        end
        ST_LT: begin
          if (ch == CH_EQ) begin
            res[nres[0]] = mk_res(K_LE, E_NONE, ln, {CH_LT, CH_EQ, 48'd0}, 4'd2);
          end else begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_LT, 56'd0}, 4'd1);
            restart = 1'b1;
          end
          nres = nres + 2'd1;
          st = ST_START;
        end
        ST_GT: begin
          if (ch == CH_EQ) begin
            res[nres[0]] = mk_res(K_GE, E_NONE, ln, {CH_GT, CH_EQ, 48'd0}, 4'd2);
          end else begin
            res[nres[0]] = mk_res(K_ERR, E_INCOMPLETE, ln, {CH_GT, 56'd0}, 4'd1);
            restart = 1'b1;
          end
          nres = nres + 2'd1;
          st = ST_START;
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    // Scan the character from the start state.
    if (restart) begin
      st = ST_START;
      bf = '0;
      ct = '0;
      if (is_space(ch)) begin
        if (ch == CH_NEWLINE) begin
          ln = ln + 16'd1;
        end
      end else if (is_alpha(ch)) begin
        st = ST_IDENT;
        do_append = 1'b1;
      end else if (is_digit(ch)) begin
        st = ST_NUM;
        do_append = 1'b1;
      end else if (ch == CH_HASH) begin
        ic = 1'b1;
        cs = ln;
      end else if (ch == CH_EQ) begin
        st = ST_EQ;
      end else if (ch == CH_COLON) begin
        st = ST_COLON;
      end else if (ch == CH_BANG) begin
        st = ST_BANG;
      end else if (ch == CH_LT) begin
        st = ST_LT;
      end else if (ch == CH_GT) begin
        st = ST_GT;
      end else if (opk != K_EOF) begin
        res[nres[0]] = mk_res(opk, E_NONE, ln, {ch, 56'd0}, 4'd1);
        nres = nres + 2'd1;
      end else begin
        res[nres[0]] = mk_res(K_ERR, E_INVALID, ln, {ch, 56'd0}, 4'd1);
        nres = nres + 2'd1;
      end
    end

    // Add the character to the token text, or report an overlong token.
    if (do_append) begin
      if (ct >= MaxLen) begin
        res[nres[0]] = mk_res(K_ERR, E_TOO_LONG, ln, bf, ct);
        nres = nres + 2'd1;
        st = ST_START;
        bf = '0;
        ct = '0;
      end else begin
        bf[8 * (3'd7 - ct[2:0]) +: 8] = ch;
        ct = ct + 4'd1;
      end
    end

    // Mark the final result of this character.
    if (nres == 2'd2) begin
      res[1].last = 1'b1;
    end else if (nres == 2'd1) begin
      res[0].last = 1'b1;
    end
  end

  assign res0 = res[0];
  assign res1 = res[1];

  // Scanner state update on each transfer without a configuration write; a configuration write loads the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state         <= ST_START;
      text_buffer        <= '0;
      text_count         <= '0;
      line_counter       <= 16'd1;
      in_comment         <= 1'b0;
      comment_start_line <= '0;
    end else if (cfg_we) begin
      line_counter <= cfg_wdata;
    end else if (accept) begin
      scan_state         <= st;
      text_buffer        <= bf;
      text_count         <= ct;
      line_counter       <= ln;
      in_comment         <= ic;
      comment_start_line <= cs;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tdl_res_fifo.sv =====
// Result queue that takes up to two results per cycle and hands out one.
`default_nettype none

module tdl_res_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  wire tdl_pkg::result_t push0,
  input  wire tdl_pkg::result_t push1,
  input  wire logic             pop,
  output tdl_pkg::result_t      head,
  output logic                  not_empty,
  output logic                  room2
);
  import tdl_pkg::*;

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_pop;

  assign do_pop     = pop && not_empty;
  assign not_empty  = (count != '0);
  assign room2      = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign head       = mem[rp];
  assign count_next = count + CNT_W'(push_n) - CNT_W'(do_pop);

  // Storage writes at the tail, one or two entries.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp + PTR_W'(1)] <= push1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + PTR_W'(push_n);
      rp    <= rp + PTR_W'(do_pop);
      count <= count_next;
    end
  end

endmodule

`default_nettype wire
